// ===== src/bpc_pkg.sv =====
// bpc_pkg: shared constants, codes and types for the barometer compensation block
// no dependencies; imported by the channel interfaces, the multiplier and the top level
package bpc_pkg;

   localparam int RAW_W      = 24;
   localparam int CAL_W      = 16;
   localparam int CAL_COUNT  = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int DELTA_W    = 26;
   localparam int T1_W       = 19;
   localparam int TEMP_W     = 20;
   localparam int PRES_W     = 27;
   localparam int ACC_W      = 40;

   // shared multiplier geometry
   localparam int MUL_A_W    = 40;
   localparam int DIGIT_W    = 8;
   localparam int MUL_DIGITS = 4;
   localparam int MUL_B_W    = DIGIT_W * MUL_DIGITS;
   localparam int PROD_W     = 64;
   localparam int PART_W     = MUL_A_W + DIGIT_W + 1;
   localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);

   // temperature thresholds in hundredths of a degree
   localparam int T_REF      = 2000;
   localparam int T_LOW      = -1500;

   // scaling shifts
   localparam int REF_TEMP_SHIFT = 8;
   localparam int T1_SHIFT       = 23;
   localparam int T2_SHIFT       = 31;
   localparam int OFF_BASE_SHIFT = 16;
   localparam int OFF_COEF_SHIFT = 7;
   localparam int SENS_BASE_SHIFT = 15;
   localparam int SENS_COEF_SHIFT = 8;
   localparam int PROD_SHIFT     = 21;
   localparam int PRES_SHIFT     = 15;

   localparam logic OP_PRESSURE    = 1'b0;
   localparam logic OP_TEMPERATURE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESSURE_SENS    = 3'd0,
      CSR_PRESSURE_OFFSET  = 3'd1,
      CSR_SENS_TEMP_COEF   = 3'd2,
      CSR_OFFSET_TEMP_COEF = 3'd3,
      CSR_REF_TEMP         = 3'd4,
      CSR_TEMP_SLOPE       = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                        start;
      logic signed [MUL_A_W-1:0]   a;
      logic signed [MUL_B_W-1:0]   b;
   } mul_cmd_type;

   typedef struct packed {
      logic                        done;
      logic signed [PROD_W-1:0]    product;
   } mul_sts_type;

endpackage

// ===== src/bpc_channels.sv =====
// bpc channel interfaces: request, response and csr write channels
// depends on bpc_pkg for field widths
interface bpc_req_if import bpc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             op;
   logic [RAW_W-1:0] raw_reading;
   modport source (output valid, op, raw_reading, input ready);
   modport sink   (input valid, op, raw_reading, output ready);
endinterface

interface bpc_rsp_if import bpc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic signed [TEMP_W-1:0] temp_centideg;
   logic signed [PRES_W-1:0] pressure_pa;
   modport source (output valid, kind, temp_centideg, pressure_pa, input ready);
   modport sink   (input valid, kind, temp_centideg, pressure_pa, output ready);
endinterface

interface bpc_csr_if import bpc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CAL_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/bpc_mul.sv =====
// bpc_mul: shared signed multiplier, one 8-bit digit of b per cycle, msb digit first
// depends on bpc_pkg for widths and the command/status structs
module bpc_mul import bpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_cmd_type cmd,
   output mul_sts_type sts
);

   logic signed [MUL_A_W-1:0] a_ff;
   logic [MUL_B_W-1:0]        b_ff;
   logic signed [PROD_W-1:0]  acc_ff;
   logic [MUL_CNT_W-1:0]      cnt_ff;
   logic                      busy_ff;
   logic                      first_ff;
   logic                      done_ff;

   logic signed [PART_W-1:0]  a_ext;
   logic signed [PART_W-1:0]  digit_ext;
   logic signed [PART_W-1:0]  partial;
   logic signed [PROD_W-1:0]  acc_in;

   always_comb begin
      a_ext = PART_W'(a_ff);
      // top digit carries the sign of b, the rest are unsigned
      if (first_ff) begin
         digit_ext = PART_W'($signed(b_ff[MUL_B_W-1 -: DIGIT_W]));
      end else begin
         digit_ext = $signed({{(PART_W-DIGIT_W){1'b0}}, b_ff[MUL_B_W-1 -: DIGIT_W]});
      end
      partial = a_ext * digit_ext;
      acc_in  = (acc_ff <<< DIGIT_W) + PROD_W'(partial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         first_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            a_ff     <= cmd.a;
            b_ff     <= cmd.b;
            acc_ff   <= '0;
            cnt_ff   <= '0;
            busy_ff  <= 1'b1;
            first_ff <= 1'b1;
         end else if (busy_ff) begin
            acc_ff   <= acc_in;
            b_ff     <= b_ff << DIGIT_W;
            first_ff <= 1'b0;
            cnt_ff   <= cnt_ff + 1'b1;
            if (cnt_ff == MUL_CNT_W'(MUL_DIGITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.done    = done_ff;
   assign sts.product = acc_ff;

endmodule

// ===== src/baro_pressure_temperature_compensation.sv =====
// barometer compensation top level: sequencer, calibration registers and result register
// depends on bpc_pkg, the bpc channel interfaces and bpc_mul
// a temperature response follows the dT, first-order and second-order temperature steps;
// a pressure response follows the offset, sensitivity, optional low-temperature and pressure
// multiplies; one request at a time, paced by the single shared digit-serial multiplier,
// and a new request is taken while a response still waits
// synchronous reset clears calibration words, stored temperature and pressure to zero
module baro_pressure_temperature_compensation import bpc_pkg::*; (
   input logic      clock,
   input logic      reset,
   bpc_req_if.sink  req_chan,
   bpc_rsp_if.source rsp_chan,
   bpc_csr_if.sink  csr_chan
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_TEMP_DT,
      S_TEMP_T1,
      S_TEMP_TC,
      S_PRES_OFF,
      S_PRES_SENS,
      S_PRES_SQ,
      S_PRES_SQ2,
      S_PRES_P,
      S_OUT
   } state_type;

   state_type state_ff;

   // calibration words
   logic [CAL_W-1:0] cal_ff [CAL_COUNT];

   // stored state carried between requests
   logic signed [DELTA_W-1:0] temp_delta_ff;
   logic signed [T1_W-1:0]    first_order_temp_ff;
   logic signed [TEMP_W-1:0]  compensated_temp_ff;
   logic signed [PRES_W-1:0]  last_pressure_ff;

   // per-request working registers
   logic             op_ff;
   logic [RAW_W-1:0] raw_ff;
   logic signed [ACC_W-1:0] off_ff;
   logic signed [ACC_W-1:0] sens_ff;

   // response register
   logic                     rsp_valid_ff;
   logic                     rsp_kind_ff;
   logic signed [TEMP_W-1:0] rsp_temp_ff;
   logic signed [PRES_W-1:0] rsp_pres_ff;

   mul_cmd_type mul_cmd_ff;
   mul_sts_type mul_sts;

   bpc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd_ff),
      .sts   (mul_sts)
   );

   // csr writes, indexes beyond the list are dropped
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAL_COUNT; i++) begin
            cal_ff[i] <= '0;
         end
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_PRESSURE_SENS:    cal_ff[CSR_PRESSURE_SENS]    <= csr_chan.data;
            CSR_PRESSURE_OFFSET:  cal_ff[CSR_PRESSURE_OFFSET]  <= csr_chan.data;
            CSR_SENS_TEMP_COEF:   cal_ff[CSR_SENS_TEMP_COEF]   <= csr_chan.data;
            CSR_OFFSET_TEMP_COEF: cal_ff[CSR_OFFSET_TEMP_COEF] <= csr_chan.data;
            CSR_REF_TEMP:         cal_ff[CSR_REF_TEMP]         <= csr_chan.data;
            CSR_TEMP_SLOPE:       cal_ff[CSR_TEMP_SLOPE]       <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // datapath around the multiplier result
   logic signed [PROD_W-1:0]  prod;
   logic signed [DELTA_W-1:0] dt_calc;
   logic signed [PROD_W-1:0]  t1_ext;
   logic signed [PROD_W-1:0]  t1_wide;
   logic signed [PROD_W-1:0]  tc_wide;
   logic signed [PROD_W-1:0]  d_wide;
   logic signed [PROD_W-1:0]  e_wide;
   logic signed [PROD_W-1:0]  off_base;
   logic signed [PROD_W-1:0]  sens_base;
   logic signed [PROD_W-1:0]  five_sq;
   logic signed [PROD_W-1:0]  off_sq;
   logic signed [PROD_W-1:0]  sens_sq;
   logic signed [PROD_W-1:0]  seven_sq2;
   logic signed [PROD_W-1:0]  eleven_sq2;
   logic signed [PROD_W-1:0]  off_sq2;
   logic signed [PROD_W-1:0]  sens_sq2;
   logic signed [PROD_W-1:0]  pres_wide;
   logic                      t1_cold;
   logic                      t1_frigid;

   always_comb begin
      prod    = mul_sts.product;
      // dt = raw - c5 * 256
      dt_calc = $signed({2'b00, raw_ff})
              - $signed({2'b00, cal_ff[CSR_REF_TEMP], {REF_TEMP_SHIFT{1'b0}}});
      t1_wide = PROD_W'(T_REF) + (prod >>> T1_SHIFT);
      t1_ext  = PROD_W'(first_order_temp_ff);
      t1_cold   = t1_ext < PROD_W'(T_REF);
      t1_frigid = t1_ext < PROD_W'(T_LOW);
      // square correction, dt^2 is never negative
      tc_wide = t1_ext - (prod >>> T2_SHIFT);
      d_wide  = t1_ext - PROD_W'(T_REF);
      e_wide  = t1_ext - PROD_W'(T_LOW);

      off_base  = ($signed(PROD_W'(cal_ff[CSR_PRESSURE_OFFSET])) <<< OFF_BASE_SHIFT)
                + (prod >>> OFF_COEF_SHIFT);
      sens_base = ($signed(PROD_W'(cal_ff[CSR_PRESSURE_SENS])) <<< SENS_BASE_SHIFT)
                + (prod >>> SENS_COEF_SHIFT);

      // second order below 20 C: off -= 5*sq/2, sens -= 5*sq/4
      five_sq = (prod <<< 2) + prod;
      off_sq  = PROD_W'(off_ff) - (five_sq >>> 1);
      sens_sq = PROD_W'(sens_ff) - (five_sq >>> 2);

      // further below -15 C: off -= 7*sq2, sens -= 11*sq2/2
      seven_sq2  = (prod <<< 3) - prod;
      eleven_sq2 = (prod <<< 3) + (prod <<< 1) + prod;
      off_sq2    = PROD_W'(off_ff) - seven_sq2;
      sens_sq2   = PROD_W'(sens_ff) - (eleven_sq2 >>> 1);

      pres_wide = ((prod >>> PROD_SHIFT) - PROD_W'(off_ff)) >>> PRES_SHIFT;
   end

   assign req_chan.ready = (state_ff == S_IDLE);

   // sequencer: each step launches the next multiply when the previous one is done
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= S_IDLE;
         rsp_valid_ff        <= 1'b0;
         mul_cmd_ff.start    <= 1'b0;
         temp_delta_ff       <= '0;
         first_order_temp_ff <= '0;
         compensated_temp_ff <= '0;
         last_pressure_ff    <= '0;
      end else begin
         mul_cmd_ff.start <= 1'b0;
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  op_ff  <= req_chan.op;
                  raw_ff <= req_chan.raw_reading;
                  if (req_chan.op == OP_TEMPERATURE) begin
                     state_ff <= S_TEMP_DT;
                  end else begin
                     // offset coefficient times the stored dt
                     mul_cmd_ff.start <= 1'b1;
                     mul_cmd_ff.a     <= MUL_A_W'(cal_ff[CSR_OFFSET_TEMP_COEF]);
                     mul_cmd_ff.b     <= MUL_B_W'(temp_delta_ff);
                     state_ff         <= S_PRES_OFF;
                  end
               end
            end
            S_TEMP_DT: begin
               temp_delta_ff    <= dt_calc;
               mul_cmd_ff.start <= 1'b1;
               mul_cmd_ff.a     <= MUL_A_W'(cal_ff[CSR_TEMP_SLOPE]);
               mul_cmd_ff.b     <= MUL_B_W'(dt_calc);
               state_ff         <= S_TEMP_T1;
            end
            S_TEMP_T1: begin
               if (mul_sts.done) begin
                  first_order_temp_ff <= t1_wide[T1_W-1:0];
                  mul_cmd_ff.start    <= 1'b1;
                  mul_cmd_ff.a        <= MUL_A_W'(temp_delta_ff);
                  mul_cmd_ff.b        <= MUL_B_W'(temp_delta_ff);
                  state_ff            <= S_TEMP_TC;
               end
            end
            S_TEMP_TC: begin
               if (mul_sts.done) begin
                  if (t1_cold) begin
                     compensated_temp_ff <= tc_wide[TEMP_W-1:0];
                  end else begin
                     compensated_temp_ff <= TEMP_W'(first_order_temp_ff);
                  end
                  state_ff <= S_OUT;
               end
            end
            S_PRES_OFF: begin
               if (mul_sts.done) begin
                  off_ff           <= off_base[ACC_W-1:0];
                  mul_cmd_ff.start <= 1'b1;
                  mul_cmd_ff.a     <= MUL_A_W'(cal_ff[CSR_SENS_TEMP_COEF]);
                  mul_cmd_ff.b     <= MUL_B_W'(temp_delta_ff);
                  state_ff         <= S_PRES_SENS;
               end
            end
            S_PRES_SENS: begin
               if (mul_sts.done) begin
                  sens_ff          <= sens_base[ACC_W-1:0];
                  mul_cmd_ff.start <= 1'b1;
                  if (t1_cold) begin
                     mul_cmd_ff.a <= d_wide[MUL_A_W-1:0];
                     mul_cmd_ff.b <= d_wide[MUL_B_W-1:0];
                     state_ff     <= S_PRES_SQ;
                  end else begin
                     mul_cmd_ff.a <= sens_base[MUL_A_W-1:0];
                     mul_cmd_ff.b <= MUL_B_W'(raw_ff);
                     state_ff     <= S_PRES_P;
                  end
               end
            end
            S_PRES_SQ: begin
               if (mul_sts.done) begin
                  off_ff           <= off_sq[ACC_W-1:0];
                  sens_ff          <= sens_sq[ACC_W-1:0];
                  mul_cmd_ff.start <= 1'b1;
                  if (t1_frigid) begin
                     mul_cmd_ff.a <= e_wide[MUL_A_W-1:0];
                     mul_cmd_ff.b <= e_wide[MUL_B_W-1:0];
                     state_ff     <= S_PRES_SQ2;
                  end else begin
                     mul_cmd_ff.a <= sens_sq[MUL_A_W-1:0];
                     mul_cmd_ff.b <= MUL_B_W'(raw_ff);
                     state_ff     <= S_PRES_P;
                  end
               end
            end
            S_PRES_SQ2: begin
               if (mul_sts.done) begin
                  off_ff           <= off_sq2[ACC_W-1:0];
                  mul_cmd_ff.start <= 1'b1;
                  mul_cmd_ff.a     <= sens_sq2[MUL_A_W-1:0];
                  mul_cmd_ff.b     <= MUL_B_W'(raw_ff);
                  state_ff         <= S_PRES_P;
               end
            end
            S_PRES_P: begin
               if (mul_sts.done) begin
                  last_pressure_ff <= pres_wide[PRES_W-1:0];
                  state_ff         <= S_OUT;
               end
            end
            S_OUT: begin
               // load the response once the previous one has left
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= op_ff;
                  rsp_temp_ff  <= compensated_temp_ff;
                  rsp_pres_ff  <= last_pressure_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_kind_ff;
   assign rsp_chan.temp_centideg = rsp_temp_ff;
   assign rsp_chan.pressure_pa   = rsp_pres_ff;

endmodule

// ===== src/bpc_checker.sv =====
// bpc_checker: port-level assertions for the barometer compensation top level
// depends on bpc_pkg; bound to the top level at the end of this file
module bpc_checker import bpc_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     rsp_kind,
   input logic signed [TEMP_W-1:0] rsp_temp,
   input logic signed [PRES_W-1:0] rsp_pres
);

   // response stays up until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kind) && $stable(rsp_temp) && $stable(rsp_pres))
      else $error("stalled response payload changed");

   // one request at a time: busy right after taking one
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while still working");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind baro_pressure_temperature_compensation bpc_checker u_bpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_kind  (rsp_chan.kind),
   .rsp_temp  (rsp_chan.temp_centideg),
   .rsp_pres  (rsp_chan.pressure_pa)
);

// ===== tb/baro_pressure_temperature_compensation_tb.sv =====
// self-checking testbench for the barometer compensation block: directed corner
// readings, then random temperature/pressure pairs under several calibration sets
// depends on bpc_pkg, the bpc channel interfaces and the block's top level
module baro_pressure_temperature_compensation_tb;
   import bpc_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int unsigned DRAIN_CYCLES  = 40;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned PHASE_ITEMS   = 135;

   // indexes past the last calibration word, the block must ignore writes there
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic [RAW_W-1:0] RAW_MAX = '1;
   localparam longint           RAW_TOP = 64'd16777215;

   // reference temperature reading of 2^23 with a slope of 2^15 makes
   // T1 = 2000 + dT / 256, so the thresholds can be hit exactly
   localparam logic [RAW_W-1:0] RAW_AT_REF     = 24'd8388608;
   localparam logic [RAW_W-1:0] RAW_BELOW_REF  = 24'd8388607;
   localparam logic [RAW_W-1:0] RAW_AT_LOW     = 24'd7492608;
   localparam logic [RAW_W-1:0] RAW_BELOW_LOW  = 24'd7492352;

   typedef logic [CAL_W-1:0] cal_set_type [CAL_COUNT];

   typedef struct {
      logic                     kind;
      logic signed [TEMP_W-1:0] temp_centideg;
      logic signed [PRES_W-1:0] pressure_pa;
   } reading_result_type;

   // typical factory words, and the same set with the threshold-friendly
   // reference temperature and slope
   localparam cal_set_type CAL_TYPICAL  = '{16'd40127, 16'd36924, 16'd23317,
                                            16'd23282, 16'd33464, 16'd28312};
   localparam cal_set_type CAL_BOUNDARY = '{16'd40127, 16'd36924, 16'd23317,
                                            16'd23282, 16'h8000, 16'h8000};
   localparam cal_set_type CAL_ZERO     = '{default: '0};
   localparam cal_set_type CAL_FULL     = '{default: '1};

   // compensation scoreboard: own copy of calibration and stored readings,
   // predicts one result per request and checks results in order
   class compensation_scoreboard;
      longint             cal_word [CAL_COUNT];
      longint             temp_delta;
      longint             first_order_temp;
      longint             compensated_temp;
      longint             last_pressure;
      reading_result_type expected_results [$];
      int unsigned        faults;

      function new();
         foreach (cal_word[i])
            cal_word[i] = 0;
         temp_delta       = 0;
         first_order_temp = 0;
         compensated_temp = 0;
         last_pressure    = 0;
         faults           = 0;
      endfunction

      function void write_cal(logic [CSR_IDX_W-1:0] index, logic [CAL_W-1:0] data);
         if (index < CAL_COUNT)
            cal_word[index] = data;
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction

      function void note_reading(logic op, logic [RAW_W-1:0] raw_reading);
         longint             raw;
         longint             offset;
         longint             sens;
         longint             below;
         longint             square;
         reading_result_type res;
         raw = raw_reading;
         if (op == OP_TEMPERATURE) begin
            temp_delta       = raw - cal_word[CSR_REF_TEMP] * 256;
            first_order_temp = 2000 + ((temp_delta * cal_word[CSR_TEMP_SLOPE]) >>> 23);
            compensated_temp = first_order_temp;
            if (first_order_temp < 2000)
               compensated_temp -= (temp_delta * temp_delta) >>> 31;
         end else begin
            offset = cal_word[CSR_PRESSURE_OFFSET] * 65536
                     + ((cal_word[CSR_OFFSET_TEMP_COEF] * temp_delta) >>> 7);
            sens   = cal_word[CSR_PRESSURE_SENS] * 32768
                     + ((cal_word[CSR_SENS_TEMP_COEF] * temp_delta) >>> 8);
            if (first_order_temp < 2000) begin
               below  = first_order_temp - 2000;
               square = below * below;
               offset -= (5 * square) >>> 1;
               sens   -= (5 * square) >>> 2;
               if (first_order_temp < -1500) begin
                  below  = first_order_temp + 1500;
                  square = below * below;
                  offset -= 7 * square;
                  sens   -= (11 * square) >>> 1;
               end
            end
            last_pressure = (((raw * sens) >>> 21) - offset) >>> 15;
         end
         res.kind          = op;
         res.temp_centideg = compensated_temp[TEMP_W-1:0];
         res.pressure_pa   = last_pressure[PRES_W-1:0];
         expected_results.push_back(res);
      endfunction

      function void flag(string field, longint want, longint got);
         faults++;
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      endfunction

      function void check_reading_result(logic kind, logic signed [TEMP_W-1:0] temp,
                                         logic signed [PRES_W-1:0] pres);
         reading_result_type want;
         if (expected_results.size() == 0) begin
            flag("unexpected result, kind", -1, kind);
            return;
         end
         want = expected_results.pop_front();
         if (kind !== want.kind)
            flag("kind", want.kind, kind);
         if (temp !== want.temp_centideg)
            flag("temp_centideg", want.temp_centideg, temp);
         if (pres !== want.pressure_pa)
            flag("pressure_pa", want.pressure_pa, pres);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        steady = 1'b0;
   int unsigned sent_count = 0;
   int unsigned cycle_count = 0;

   compensation_scoreboard sb = new();

   bpc_req_if req_bus ();
   bpc_rsp_if rsp_bus ();
   bpc_csr_if csr_bus ();

   baro_pressure_temperature_compensation dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_chan  (csr_bus)
   );

   always #2 clock = ~clock;

   // watchdog on a runaway or hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // response side: check every taken response, then stall at random
   // except during the steady stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_reading_result(rsp_bus.kind, rsp_bus.temp_centideg,
                                    rsp_bus.pressure_pa);
         rsp_bus.ready <= steady || ($urandom_range(99) >= 15);
      end
   end

   // raw value for one conversion: sometimes an extreme, temperatures often
   // near the reference reading so every temperature band gets visited
   function automatic logic [RAW_W-1:0] pick_raw(input logic op);
      longint      centre;
      longint      spread;
      longint      value;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10)
         return roll[0] ? RAW_MAX : '0;
      if (op == OP_TEMPERATURE && roll < 60) begin
         centre = sb.cal_word[CSR_REF_TEMP] * 256;
         spread = $urandom_range(0, 1 << $urandom_range(4, 22));
         value  = roll[0] ? centre + spread : centre - spread;
         if (value < 0)
            value = 0;
         if (value > RAW_TOP)
            value = RAW_TOP;
         return value[RAW_W-1:0];
      end
      return RAW_W'($urandom());
   endfunction

   // one request; valid stays high after acceptance so back-to-back
   // requests need no extra edge
   task automatic send_reading(input logic op, input logic [RAW_W-1:0] raw);
      while (!steady && $urandom_range(99) < 15) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.op          <= op;
      req_bus.raw_reading <= raw;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      sb.note_reading(op, raw);
      sent_count++;
      // long stretch with no idling on either side
      steady <= (sent_count >= 500 && sent_count < 700);
   endtask

   // stop sending and wait until every result has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CAL_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      sb.write_cal(index, data);
   endtask

   // calibration only changes while the block is idle
   task automatic load_calibration(input cal_set_type words, input bit poke_spare);
      int i;
      wait_drained();
      for (i = 0; i < CAL_COUNT; i++)
         write_csr(CSR_IDX_W'(i), words[i]);
      if (poke_spare) begin
         write_csr(CSR_SPARE_LO, '1);
         write_csr(CSR_SPARE_HI, 16'h5a5a);
      end
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_random_readings(input int unsigned count);
      int unsigned done;
      logic        op;
      done = 0;
      while (done < count) begin
         // mostly well-formed temperature then pressure pairs
         if ($urandom_range(99) < 75) begin
            send_reading(OP_TEMPERATURE, pick_raw(OP_TEMPERATURE));
            send_reading(OP_PRESSURE, pick_raw(OP_PRESSURE));
            done += 2;
         end else begin
            op = 1'($urandom_range(1));
            send_reading(op, pick_raw(op));
            done++;
         end
      end
   endtask

   initial begin
      cal_set_type words;
      int unsigned phase;
      int unsigned roll;
      clock               = 1'b0;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.op          = OP_PRESSURE;
      req_bus.raw_reading = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_PRESSURE_SENS;
      csr_bus.data        = '0;
      rsp_bus.ready       = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // pressure before any temperature, first with reset calibration,
      // then with real words: stored dT and T1 are still zero
      send_reading(OP_PRESSURE, '0);
      load_calibration(CAL_TYPICAL, 1'b1);
      send_reading(OP_PRESSURE, RAW_MAX);
      send_reading(OP_PRESSURE, '0);

      // threshold edges: T1 at 2000, 1999, -1500 and -1501
      load_calibration(CAL_BOUNDARY, 1'b0);
      send_reading(OP_TEMPERATURE, RAW_AT_REF);
      send_reading(OP_PRESSURE, RAW_AT_REF);
      send_reading(OP_TEMPERATURE, RAW_BELOW_REF);
      send_reading(OP_PRESSURE, RAW_MAX);
      send_reading(OP_TEMPERATURE, RAW_AT_LOW);
      send_reading(OP_PRESSURE, '0);
      send_reading(OP_TEMPERATURE, RAW_BELOW_LOW);
      send_reading(OP_PRESSURE, RAW_MAX);

      // largest words with extreme readings, deepest cold corrections
      load_calibration(CAL_FULL, 1'b0);
      send_reading(OP_TEMPERATURE, '0);
      send_reading(OP_PRESSURE, RAW_MAX);
      send_reading(OP_TEMPERATURE, RAW_MAX);
      send_reading(OP_PRESSURE, '0);

      load_calibration(CAL_ZERO, 1'b0);
      send_reading(OP_TEMPERATURE, RAW_MAX);
      send_reading(OP_PRESSURE, RAW_MAX);

      // random phases, each under its own calibration set
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               words = CAL_TYPICAL;
            end
            2: begin
               words = CAL_FULL;
            end
            5: begin
               words = CAL_ZERO;
            end
            default: begin
               foreach (words[i]) begin
                  roll = $urandom_range(9);
                  words[i] = (roll == 0) ? '0 : (roll == 1) ? '1 : CAL_W'($urandom());
               end
            end
         endcase
         load_calibration(words, phase == 3);
         run_random_readings(PHASE_ITEMS);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.faults == 0 && sb.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
src/bpc_pkg.sv
src/bpc_channels.sv
src/bpc_mul.sv
src/baro_pressure_temperature_compensation.sv
src/bpc_checker.sv
tb/baro_pressure_temperature_compensation_tb.sv
